[rtl/hrp_pkg.sv]
// Package for the HTTP request parser: phase codes, status codes, keyword
// tables and the result record. No dependencies.
package hrp_pkg;

	localparam int BufferBytes = 2048;
	localparam int BcW = $clog2(BufferBytes + 1);
	localparam int PosW = 11;

	// parse phases
	localparam logic [3:0] PH_METHOD    = 4'd0;
	localparam logic [3:0] PH_URL       = 4'd1;
	localparam logic [3:0] PH_VERSION   = 4'd2;
	localparam logic [3:0] PH_HNAME     = 4'd3;
	localparam logic [3:0] PH_CONN_SKIP = 4'd4;
	localparam logic [3:0] PH_CONN_VAL  = 4'd5;
	localparam logic [3:0] PH_HOST_SKIP = 4'd6;
	localparam logic [3:0] PH_HOST_VAL  = 4'd7;
	localparam logic [3:0] PH_LEN_SKIP  = 4'd8;
	localparam logic [3:0] PH_LEN_DIG   = 4'd9;
	localparam logic [3:0] PH_LEN_DONE  = 4'd10;
	localparam logic [3:0] PH_SKIPLINE  = 4'd11;
	localparam logic [3:0] PH_BODY      = 4'd12;
	localparam logic [3:0] PH_DONE      = 4'd13;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// keyword lengths
	localparam logic [4:0] LenGet  = 5'd3;
	localparam logic [4:0] LenVer  = 5'd8;
	localparam logic [4:0] LenPfx  = 5'd7;
	localparam logic [4:0] LenConn = 5'd11;
	localparam logic [4:0] LenHost = 5'd5;
	localparam logic [4:0] LenClen = 5'd15;
	localparam logic [4:0] LenKa   = 5'd10;

	typedef struct packed {
		logic [1:0]  status;
		logic        keep_alive;
		logic [10:0] url_start;
		logic [10:0] url_length;
		logic [10:0] host_start;
		logic [10:0] host_length;
		logic [31:0] declared_length;
		logic [11:0] body_start;
	} result_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	function automatic logic is_sep(input logic [7:0] b);
		return b == CH_SP || b == CH_TAB;
	endfunction

	// keyword lookups, lower case
	function automatic logic [7:0] kw_get(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "g";
			5'd1: c = "e";
			5'd2: c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_ver(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "h";
			5'd1: c = "t";
			5'd2: c = "t";
			5'd3: c = "p";
			5'd4: c = "/";
			5'd5: c = "1";
			5'd6: c = ".";
			5'd7: c = "1";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_pfx(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "h";
			5'd1: c = "t";
			5'd2: c = "t";
			5'd3: c = "p";
			5'd4: c = ":";
			5'd5: c = "/";
			5'd6: c = "/";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_conn(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "c";
			5'd1: c = "o";
			5'd2: c = "n";
			5'd3: c = "n";
			5'd4: c = "e";
			5'd5: c = "c";
			5'd6: c = "t";
			5'd7: c = "i";
			5'd8: c = "o";
			5'd9: c = "n";
			5'd10: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_host(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "h";
			5'd1: c = "o";
			5'd2: c = "s";
			5'd3: c = "t";
			5'd4: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_clen(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "c";
			5'd1: c = "o";
			5'd2: c = "n";
			5'd3: c = "t";
			5'd4: c = "e";
			5'd5: c = "n";
			5'd6: c = "t";
			5'd7: c = "-";
			5'd8: c = "l";
			5'd9: c = "e";
			5'd10: c = "n";
			5'd11: c = "g";
			5'd12: c = "t";
			5'd13: c = "h";
			5'd14: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_ka(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "k";
			5'd1: c = "e";
			5'd2: c = "e";
			5'd3: c = "p";
			5'd4: c = "-";
			5'd5: c = "a";
			5'd6: c = "l";
			5'd7: c = "i";
			5'd8: c = "v";
			5'd9: c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/hrp_in_if.sv]
// Input channel of the HTTP request parser: one request byte per transaction.
// No dependencies.
interface hrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_connection;

	modport source (output valid, output data_byte, output new_connection, input ready);
	modport sink (input valid, input data_byte, input new_connection, output ready);
endinterface

[rtl/hrp_out_if.sv]
// Output channel of the HTTP request parser: one parse result per transaction.
// No dependencies.
interface hrp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        keep_alive;
	logic [10:0] url_start;
	logic [10:0] url_length;
	logic [10:0] host_start;
	logic [10:0] host_length;
	logic [31:0] declared_length;
	logic [11:0] body_start;

	modport source (output valid, output status, output keep_alive, output url_start,
		output url_length, output host_start, output host_length, output declared_length,
		output body_start, input ready);
	modport sink (input valid, input status, input keep_alive, input url_start,
		input url_length, input host_start, input host_length, input declared_length,
		input body_start, output ready);
endinterface

[rtl/http_request_parser.sv]
// HTTP/1.1 GET request parser top level.
// Depends on hrp_pkg, hrp_in_if and hrp_out_if.
//
// Takes one request byte per clock while input ready is high. The byte is
// matched against the request line and header keywords in the same cycle it
// is accepted; the parser state and the result register update at that edge.
// Input ready only drops while a finished result waits in the output register
// and the sink is not taking it. After a result, bytes are swallowed until a
// byte arrives with new_connection set. Offsets count from the byte that
// carries new_connection.
module http_request_parser (
	input  logic      clk,
	input  logic      arst_n,
	hrp_in_if.sink    in_ch,
	hrp_out_if.source out_ch
);

	localparam int BcW  = hrp_pkg::BcW;
	localparam int PosW = hrp_pkg::PosW;

	logic [3:0]     phase_q;
	logic [BcW-1:0] bc_q;
	logic [4:0]     mi_q;
	logic [2:0]     cand_q;
	logic           cr_q;
	logic [10:0]    url_off_q, url_size_q, host_off_q, host_size_q;
	logic [31:0]    len_q, body_q;
	logic           linger_q, vm_q;

	logic [3:0]     n_phase;
	logic [BcW-1:0] n_bc;
	logic [4:0]     n_mi;
	logic [2:0]     n_cand;
	logic           n_cr;
	logic [10:0]    n_url_off, n_url_size, n_host_off, n_host_size;
	logic [31:0]    n_len, n_body;
	logic           n_linger, n_vm;
	logic           emit;
	logic [1:0]     emit_st;
	logic [11:0]    emit_bs;

	logic              out_valid_q;
	hrp_pkg::result_t  res_q;
	hrp_pkg::result_t  res_d;
	logic              accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;

	// per-byte parser step
	always_comb begin
		logic [7:0]      b;
		logic [7:0]      c;
		logic [PosW-1:0] pos;
		logic [35:0]     prod;
		logic            ka_step;
		logic            dig_step;
		b = in_ch.data_byte;
		c = hrp_pkg::to_lower(b);
		ka_step = 1'b0;
		dig_step = 1'b0;
		prod = '0;
		emit = 1'b0;
		emit_st = hrp_pkg::ST_OK;
		emit_bs = '0;
		if (in_ch.new_connection) begin
			n_phase = hrp_pkg::PH_METHOD;
			n_bc = '0;
			n_mi = '0;
			n_cand = 3'b111;
			n_cr = 1'b0;
			n_url_off = '0;
			n_url_size = '0;
			n_host_off = '0;
			n_host_size = '0;
			n_len = '0;
			n_body = '0;
			n_linger = 1'b0;
			n_vm = 1'b1;
		end else begin
			n_phase = phase_q;
			n_bc = bc_q;
			n_mi = mi_q;
			n_cand = cand_q;
			n_cr = cr_q;
			n_url_off = url_off_q;
			n_url_size = url_size_q;
			n_host_off = host_off_q;
			n_host_size = host_size_q;
			n_len = len_q;
			n_body = body_q;
			n_linger = linger_q;
			n_vm = vm_q;
		end
		pos = n_bc[PosW-1:0];

		if (n_phase == hrp_pkg::PH_DONE) begin
			emit = 1'b0;
		end else if (n_bc >= BcW'(hrp_pkg::BufferBytes)) begin
			emit = 1'b1;
			emit_st = hrp_pkg::ST_TOO_LONG;
		end else begin
			n_bc = n_bc + 1'b1;
			if (n_phase == hrp_pkg::PH_BODY) begin
				// raw body bytes
				n_body = n_body + 32'd1;
				if (n_body >= n_len) begin
					emit = 1'b1;
					emit_bs = 12'(pos) + 12'd1 - n_body[11:0];
				end
			end else if (n_cr) begin
				// line end
				n_cr = 1'b0;
				if (b != hrp_pkg::CH_LF) begin
					emit = 1'b1;
					emit_st = hrp_pkg::ST_BAD;
				end else begin
					priority if (n_phase == hrp_pkg::PH_METHOD || n_phase == hrp_pkg::PH_URL) begin
						emit = 1'b1;
						emit_st = hrp_pkg::ST_BAD;
					end else if (n_phase == hrp_pkg::PH_VERSION &&
						!(n_vm && n_mi == hrp_pkg::LenVer)) begin
						emit = 1'b1;
						emit_st = hrp_pkg::ST_BAD;
					end else if (n_phase == hrp_pkg::PH_HNAME && n_mi == 5'd0) begin
						if (n_len != 32'd0) begin
							n_phase = hrp_pkg::PH_BODY;
							n_body = '0;
						end else begin
							emit = 1'b1;
							emit_bs = 12'(pos) + 12'd1;
						end
					end else begin
						if (n_phase == hrp_pkg::PH_CONN_VAL && n_vm && n_mi == hrp_pkg::LenKa)
							n_linger = 1'b1;
						n_phase = hrp_pkg::PH_HNAME;
						n_mi = '0;
						n_cand = 3'b111;
						n_vm = 1'b1;
					end
				end
			end else if (b == hrp_pkg::CH_CR) begin
				n_cr = 1'b1;
			end else if (b == hrp_pkg::CH_LF) begin
				emit = 1'b1;
				emit_st = hrp_pkg::ST_BAD;
			end else begin
				// line content
				case (n_phase)
					hrp_pkg::PH_METHOD: begin
						if (hrp_pkg::is_sep(b)) begin
							if (n_mi != hrp_pkg::LenGet) n_vm = 1'b0;
							n_phase = hrp_pkg::PH_URL;
							n_mi = '0;
							n_cand = 3'b001;
						end else if (n_mi < hrp_pkg::LenGet && c == hrp_pkg::kw_get(n_mi)) begin
							n_mi = n_mi + 5'd1;
						end else begin
							n_vm = 1'b0;
						end
					end
					hrp_pkg::PH_URL: begin
						if (hrp_pkg::is_sep(b)) begin
							if (!n_cand[1]) n_vm = 1'b0;
							n_phase = hrp_pkg::PH_VERSION;
							n_mi = '0;
						end else begin
							if (!n_cand[1] && b == hrp_pkg::CH_SLASH &&
								(n_mi == 5'd0 || (n_mi >= hrp_pkg::LenPfx && n_cand[0]))) begin
								n_cand[1] = 1'b1;
								n_url_off = pos;
								n_url_size = '0;
							end
							if (n_cand[1]) n_url_size = n_url_size + 11'd1;
							if (n_mi < hrp_pkg::LenPfx) begin
								if (c != hrp_pkg::kw_pfx(n_mi)) n_cand[0] = 1'b0;
								n_mi = n_mi + 5'd1;
							end
						end
					end
					hrp_pkg::PH_VERSION: begin
						if (n_mi < hrp_pkg::LenVer && c == hrp_pkg::kw_ver(n_mi))
							n_mi = n_mi + 5'd1;
						else
							n_vm = 1'b0;
					end
					hrp_pkg::PH_HNAME: begin
						if (n_cand[0] && !(n_mi < hrp_pkg::LenConn && c == hrp_pkg::kw_conn(n_mi)))
							n_cand[0] = 1'b0;
						if (n_cand[1] && !(n_mi < hrp_pkg::LenHost && c == hrp_pkg::kw_host(n_mi)))
							n_cand[1] = 1'b0;
						if (n_cand[2] && !(n_mi < hrp_pkg::LenClen && c == hrp_pkg::kw_clen(n_mi)))
							n_cand[2] = 1'b0;
						n_mi = n_mi + 5'd1;
						priority if (n_cand[0] && n_mi == hrp_pkg::LenConn) begin
							n_phase = hrp_pkg::PH_CONN_SKIP;
							n_mi = '0;
							n_vm = 1'b1;
						end else if (n_cand[1] && n_mi == hrp_pkg::LenHost) begin
							n_phase = hrp_pkg::PH_HOST_SKIP;
							n_host_off = '0;
							n_host_size = '0;
						end else if (n_cand[2] && n_mi == hrp_pkg::LenClen) begin
							n_phase = hrp_pkg::PH_LEN_SKIP;
							n_len = '0;
						end else if (n_cand == 3'b000) begin
							n_phase = hrp_pkg::PH_SKIPLINE;
						end else begin
							n_phase = hrp_pkg::PH_HNAME;
						end
					end
					hrp_pkg::PH_CONN_SKIP: begin
						if (!hrp_pkg::is_sep(b)) begin
							n_phase = hrp_pkg::PH_CONN_VAL;
							ka_step = 1'b1;
						end
					end
					hrp_pkg::PH_CONN_VAL: ka_step = 1'b1;
					hrp_pkg::PH_HOST_SKIP: begin
						if (!hrp_pkg::is_sep(b)) begin
							n_phase = hrp_pkg::PH_HOST_VAL;
							n_host_off = pos;
							n_host_size = 11'd1;
						end
					end
					hrp_pkg::PH_HOST_VAL: n_host_size = n_host_size + 11'd1;
					hrp_pkg::PH_LEN_SKIP: begin
						if (hrp_pkg::is_sep(b)) begin
							n_phase = hrp_pkg::PH_LEN_SKIP;
						end else if (b == hrp_pkg::CH_PLUS) begin
							n_phase = hrp_pkg::PH_LEN_DIG;
						end else if (b < hrp_pkg::CH_ZERO || b > hrp_pkg::CH_NINE) begin
							n_phase = hrp_pkg::PH_LEN_DONE;
						end else begin
							n_phase = hrp_pkg::PH_LEN_DIG;
							dig_step = 1'b1;
						end
					end
					hrp_pkg::PH_LEN_DIG: dig_step = 1'b1;
					default: n_phase = n_phase;
				endcase
				// keep-alive value compare
				if (ka_step) begin
					if (n_mi < hrp_pkg::LenKa && c == hrp_pkg::kw_ka(n_mi))
						n_mi = n_mi + 5'd1;
					else
						n_vm = 1'b0;
				end
				// decimal digit: value*10 + digit, saturating
				if (dig_step) begin
					if (b >= hrp_pkg::CH_ZERO && b <= hrp_pkg::CH_NINE) begin
						prod = {1'b0, n_len, 3'b000} + {3'b000, n_len, 1'b0}
							+ {32'd0, 4'(b - hrp_pkg::CH_ZERO)};
						n_len = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
					end else begin
						n_phase = hrp_pkg::PH_LEN_DONE;
					end
				end
			end
		end
		if (emit) n_phase = hrp_pkg::PH_DONE;
	end

	// result record, zeroed on error
	always_comb begin
		res_d = '0;
		res_d.status = emit_st;
		if (emit_st == hrp_pkg::ST_OK) begin
			res_d.keep_alive = n_linger;
			res_d.url_start = n_url_off;
			res_d.url_length = n_url_size;
			res_d.host_start = n_host_off;
			res_d.host_length = n_host_size;
			res_d.declared_length = n_len;
			res_d.body_start = emit_bs;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrp_pkg::PH_METHOD;
			bc_q <= '0;
			mi_q <= '0;
			cand_q <= 3'b111;
			cr_q <= 1'b0;
			url_off_q <= '0;
			url_size_q <= '0;
			host_off_q <= '0;
			host_size_q <= '0;
			len_q <= '0;
			body_q <= '0;
			linger_q <= 1'b0;
			vm_q <= 1'b1;
		end else if (accept) begin
			phase_q <= n_phase;
			bc_q <= n_bc;
			mi_q <= n_mi;
			cand_q <= n_cand;
			cr_q <= n_cr;
			url_off_q <= n_url_off;
			url_size_q <= n_url_size;
			host_off_q <= n_host_off;
			host_size_q <= n_host_size;
			len_q <= n_len;
			body_q <= n_body;
			linger_q <= n_linger;
			vm_q <= n_vm;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) res_q <= res_d;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = res_q.status;
	assign out_ch.keep_alive = res_q.keep_alive;
	assign out_ch.url_start = res_q.url_start;
	assign out_ch.url_length = res_q.url_length;
	assign out_ch.host_start = res_q.host_start;
	assign out_ch.host_length = res_q.host_length;
	assign out_ch.declared_length = res_q.declared_length;
	assign out_ch.body_start = res_q.body_start;

`ifndef ASSERT_OFF
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> phase_q == hrp_pkg::PH_DONE)
		else $error("parser not parked after result");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BcW'(hrp_pkg::BufferBytes))
		else $error("byte count beyond buffer");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != hrp_pkg::ST_OK |->
		res_q.declared_length == 32'd0 && !res_q.keep_alive && res_q.url_length == 11'd0)
		else $error("error result carries fields");
`endif

endmodule
